@@ rtl/qmr_pkg.sv @@
// Shared types and constants for the quaternion multiply and rotate unit.
// No dependencies; used by qmr_dot4 and the top level.
package qmr_pkg;

   // Operation select carried with each word through the pipeline.
   typedef enum logic {
      FUNC_PRODUCT = 1'b0,
      FUNC_ROTATE  = 1'b1
   } func_type;

   // Sign applied to one full product before it enters a sum.
   typedef enum logic {
      SIGN_PLUS  = 1'b0,
      SIGN_MINUS = 1'b1
   } sign_type;

   // Component positions inside a four-element quaternion array.
   localparam int IDX_W = 0;
   localparam int IDX_X = 1;
   localparam int IDX_Y = 2;
   localparam int IDX_Z = 3;

endpackage

@@ rtl/qmr_dot4.sv @@
// Signed sum of four full-width products, rounded half up, scaled and saturated.
// Depends on qmr_pkg for the product sign type.
module qmr_dot4 #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_BITS   = 14
) (
   input  logic signed [2*COMPONENT_WIDTH-1:0] prod [4],
   input  qmr_pkg::sign_type                   sign [4],
   output logic signed [COMPONENT_WIDTH-1:0]   result,
   output logic                                clipped
);

   localparam int PW = 2 * COMPONENT_WIDTH;
   localparam int SW = PW + 3;
   localparam logic signed [SW-1:0] ONE     = 1;
   localparam logic signed [SW-1:0] HALF    = ONE <<< (FRACTION_BITS - 1);
   localparam logic signed [SW-1:0] MAX_VAL = (ONE <<< (COMPONENT_WIDTH - 1)) - ONE;
   localparam logic signed [SW-1:0] MIN_VAL = -MAX_VAL - ONE;

   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] scaled;

   always_comb begin
      sum = HALF;
      for (int i = 0; i < 4; i++) begin
         if (sign[i] == qmr_pkg::SIGN_MINUS) begin
            sum = sum - SW'(prod[i]);
         end else begin
            sum = sum + SW'(prod[i]);
         end
      end
      scaled = sum >>> FRACTION_BITS;
      if (scaled > MAX_VAL) begin
         result  = MAX_VAL[COMPONENT_WIDTH-1:0];
         clipped = 1'b1;
      end else if (scaled < MIN_VAL) begin
         result  = MIN_VAL[COMPONENT_WIDTH-1:0];
         clipped = 1'b1;
      end else begin
         result  = scaled[COMPONENT_WIDTH-1:0];
         clipped = 1'b0;
      end
   end

endmodule

@@ rtl/quaternion_multiply_rotate.sv @@
// Top level of the fixed-point quaternion product and vector rotation unit.
// Depends on qmr_pkg and qmr_dot4.

// This unit takes one request word per clock while req_stall is low and
// returns one response word per request. With func at product it returns
// the Hamilton product a*b; with func at rotate it returns a*(0,v)*conj(a)
// for the vector v in b_x, b_y and b_z, with r_w held at zero and b_w
// ignored. The rotation is only a true rotation when a is a unit quaternion,
// since a is not normalized here. Each component is the exact sum of its
// four full products, rounded half up, shifted right by the number of
// fraction bits and saturated to the component width; the rotation's
// intermediate quaternion is rounded and saturated the same way, and any
// clipping along the way sets rsp_saturated. The work runs in five register
// stages: input capture, the first bank of sixteen multipliers, the first
// round of sums, the second bank of twelve multipliers (used for rotation
// only) and the final sums feeding the response register. Each stage moves
// forward whenever its successor is free, so bubbles close up while the
// response side stalls, and up to five words can be held in flight. The
// sustained rate is one word per cycle while the response side does not
// stall.
module quaternion_multiply_rotate #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_BITS   = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_w,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_w,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_w,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_z,
   output logic                              rsp_saturated
);

   localparam int CW = COMPONENT_WIDTH;
   localparam int PW = 2 * COMPONENT_WIDTH;

   localparam int W = qmr_pkg::IDX_W;
   localparam int X = qmr_pkg::IDX_X;
   localparam int Y = qmr_pkg::IDX_Y;
   localparam int Z = qmr_pkg::IDX_Z;

   // Stage advance enables. A stage loads when it is empty or its successor
   // loads in the same cycle, so a stall only backs up into occupied stages.
   logic en1, en2, en3, en4, en5;

   // Stage 1: captured request.
   logic                   v1_ff;
   qmr_pkg::func_type      func1_ff;
   logic signed [CW-1:0]   a1_ff [4];
   logic signed [CW-1:0]   b1_ff [4];

   // Stage 2: first products with their signs.
   logic                   v2_ff;
   qmr_pkg::func_type      func2_ff;
   logic signed [CW-1:0]   a2_ff [4];
   logic signed [PW-1:0]   p2_ff [4][4];
   qmr_pkg::sign_type      sg2_ff [4][4];

   // Stage 3: product result, or the rotation's intermediate quaternion.
   logic                   v3_ff;
   qmr_pkg::func_type      func3_ff;
   logic signed [CW-1:0]   a3_ff [4];
   logic signed [CW-1:0]   c3_ff [4];
   logic                   sat3_ff;

   // Stage 4: second products for the rotation.
   logic                   v4_ff;
   qmr_pkg::func_type      func4_ff;
   logic signed [CW-1:0]   c4_ff [4];
   logic signed [PW-1:0]   p4_ff [3][4];
   logic                   sat4_ff;

   // Stage 5: response register.
   logic                   v5_ff;
   logic signed [CW-1:0]   r_ff [4];
   logic                   sat5_ff;

   assign en5 = !v5_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall = !en1;

   // ---------------------------------------------------------------------
   // Operand selection for the first multiplier bank.
   // Rows are result components w, x, y, z; columns are the four terms.
   // For rotation the fourth term is a zero product.
   // ---------------------------------------------------------------------
   logic signed [CW-1:0]   opx [4][4];
   logic signed [CW-1:0]   opy [4][4];
   qmr_pkg::sign_type      ops [4][4];
   logic signed [PW-1:0]   p2_in [4][4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int t = 0; t < 4; t++) begin
            opx[r][t] = a1_ff[W];
            opy[r][t] = '0;
            ops[r][t] = qmr_pkg::SIGN_PLUS;
         end
      end
      case (func1_ff)
         qmr_pkg::FUNC_ROTATE: begin
            // t = a * (0, v)
            opx[W][0] = a1_ff[X]; opy[W][0] = b1_ff[X]; ops[W][0] = qmr_pkg::SIGN_MINUS;
            opx[W][1] = a1_ff[Y]; opy[W][1] = b1_ff[Y]; ops[W][1] = qmr_pkg::SIGN_MINUS;
            opx[W][2] = a1_ff[Z]; opy[W][2] = b1_ff[Z]; ops[W][2] = qmr_pkg::SIGN_MINUS;
            opx[X][0] = a1_ff[W]; opy[X][0] = b1_ff[X];
            opx[X][1] = a1_ff[Y]; opy[X][1] = b1_ff[Z];
            opx[X][2] = a1_ff[Z]; opy[X][2] = b1_ff[Y]; ops[X][2] = qmr_pkg::SIGN_MINUS;
            opx[Y][0] = a1_ff[W]; opy[Y][0] = b1_ff[Y];
            opx[Y][1] = a1_ff[Z]; opy[Y][1] = b1_ff[X];
            opx[Y][2] = a1_ff[X]; opy[Y][2] = b1_ff[Z]; ops[Y][2] = qmr_pkg::SIGN_MINUS;
            opx[Z][0] = a1_ff[W]; opy[Z][0] = b1_ff[Z];
            opx[Z][1] = a1_ff[X]; opy[Z][1] = b1_ff[Y];
            opx[Z][2] = a1_ff[Y]; opy[Z][2] = b1_ff[X]; ops[Z][2] = qmr_pkg::SIGN_MINUS;
         end
         default: begin
            // Hamilton product a * b
            opx[W][0] = a1_ff[W]; opy[W][0] = b1_ff[W];
            opx[W][1] = a1_ff[X]; opy[W][1] = b1_ff[X]; ops[W][1] = qmr_pkg::SIGN_MINUS;
            opx[W][2] = a1_ff[Y]; opy[W][2] = b1_ff[Y]; ops[W][2] = qmr_pkg::SIGN_MINUS;
            opx[W][3] = a1_ff[Z]; opy[W][3] = b1_ff[Z]; ops[W][3] = qmr_pkg::SIGN_MINUS;
            opx[X][0] = a1_ff[Y]; opy[X][0] = b1_ff[Z];
            opx[X][1] = a1_ff[Z]; opy[X][1] = b1_ff[Y]; ops[X][1] = qmr_pkg::SIGN_MINUS;
            opx[X][2] = a1_ff[W]; opy[X][2] = b1_ff[X];
            opx[X][3] = a1_ff[X]; opy[X][3] = b1_ff[W];
            opx[Y][0] = a1_ff[Z]; opy[Y][0] = b1_ff[X];
            opx[Y][1] = a1_ff[X]; opy[Y][1] = b1_ff[Z]; ops[Y][1] = qmr_pkg::SIGN_MINUS;
            opx[Y][2] = a1_ff[W]; opy[Y][2] = b1_ff[Y];
            opx[Y][3] = a1_ff[Y]; opy[Y][3] = b1_ff[W];
            opx[Z][0] = a1_ff[X]; opy[Z][0] = b1_ff[Y];
            opx[Z][1] = a1_ff[Y]; opy[Z][1] = b1_ff[X]; ops[Z][1] = qmr_pkg::SIGN_MINUS;
            opx[Z][2] = a1_ff[W]; opy[Z][2] = b1_ff[Z];
            opx[Z][3] = a1_ff[Z]; opy[Z][3] = b1_ff[W];
         end
      endcase
      for (int r = 0; r < 4; r++) begin
         for (int t = 0; t < 4; t++) begin
            p2_in[r][t] = PW'(opx[r][t]) * PW'(opy[r][t]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // First sums: four adders with rounding and saturation.
   // ---------------------------------------------------------------------
   logic signed [CW-1:0]   c3_in [4];
   logic                   clip3 [4];

   for (genvar r = 0; r < 4; r++) begin : g_sum1
      qmr_dot4 #(
         .COMPONENT_WIDTH (COMPONENT_WIDTH),
         .FRACTION_BITS   (FRACTION_BITS)
      ) u_dot (
         .prod    (p2_ff[r]),
         .sign    (sg2_ff[r]),
         .result  (c3_in[r]),
         .clipped (clip3[r])
      );
   end

   // ---------------------------------------------------------------------
   // Second multiplier bank: r = t * conj(a), vector part only.
   // Term order and signs are fixed, so only the operands are listed here.
   // ---------------------------------------------------------------------
   logic signed [CW-1:0]   qx [3][4];
   logic signed [CW-1:0]   qy [3][4];
   logic signed [PW-1:0]   p4_in [3][4];
   qmr_pkg::sign_type      sg4 [4];

   always_comb begin
      sg4[0] = qmr_pkg::SIGN_MINUS;
      sg4[1] = qmr_pkg::SIGN_PLUS;
      sg4[2] = qmr_pkg::SIGN_MINUS;
      sg4[3] = qmr_pkg::SIGN_PLUS;
      // rotated x
      qx[0][0] = c3_ff[Y]; qy[0][0] = a3_ff[Z];
      qx[0][1] = c3_ff[Z]; qy[0][1] = a3_ff[Y];
      qx[0][2] = c3_ff[W]; qy[0][2] = a3_ff[X];
      qx[0][3] = c3_ff[X]; qy[0][3] = a3_ff[W];
      // rotated y
      qx[1][0] = c3_ff[Z]; qy[1][0] = a3_ff[X];
      qx[1][1] = c3_ff[X]; qy[1][1] = a3_ff[Z];
      qx[1][2] = c3_ff[W]; qy[1][2] = a3_ff[Y];
      qx[1][3] = c3_ff[Y]; qy[1][3] = a3_ff[W];
      // rotated z
      qx[2][0] = c3_ff[X]; qy[2][0] = a3_ff[Y];
      qx[2][1] = c3_ff[Y]; qy[2][1] = a3_ff[X];
      qx[2][2] = c3_ff[W]; qy[2][2] = a3_ff[Z];
      qx[2][3] = c3_ff[Z]; qy[2][3] = a3_ff[W];
      for (int r = 0; r < 3; r++) begin
         for (int t = 0; t < 4; t++) begin
            p4_in[r][t] = PW'(qx[r][t]) * PW'(qy[r][t]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Final sums for the rotation.
   // ---------------------------------------------------------------------
   logic signed [CW-1:0]   rot5 [3];
   logic                   clip5 [3];

   for (genvar r = 0; r < 3; r++) begin : g_sum2
      qmr_dot4 #(
         .COMPONENT_WIDTH (COMPONENT_WIDTH),
         .FRACTION_BITS   (FRACTION_BITS)
      ) u_dot (
         .prod    (p4_ff[r]),
         .sign    (sg4),
         .result  (rot5[r]),
         .clipped (clip5[r])
      );
   end

   // Response selection: rotation takes the final sums and forces r_w to zero,
   // the product passes its stage 3 result straight through.
   logic signed [CW-1:0]   r_in [4];
   logic                   sat5_in;

   always_comb begin
      case (func4_ff)
         qmr_pkg::FUNC_ROTATE: begin
            r_in[W] = '0;
            r_in[X] = rot5[0];
            r_in[Y] = rot5[1];
            r_in[Z] = rot5[2];
            sat5_in = sat4_ff || clip5[0] || clip5[1] || clip5[2];
         end
         default: begin
            r_in    = c4_ff;
            sat5_in = sat4_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Valid bits.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (en1) begin
         func1_ff  <= qmr_pkg::func_type'(req_func);
         a1_ff[W]  <= req_a_w;
         a1_ff[X]  <= req_a_x;
         a1_ff[Y]  <= req_a_y;
         a1_ff[Z]  <= req_a_z;
         b1_ff[W]  <= req_b_w;
         b1_ff[X]  <= req_b_x;
         b1_ff[Y]  <= req_b_y;
         b1_ff[Z]  <= req_b_z;
      end
      if (en2) begin
         func2_ff <= func1_ff;
         a2_ff    <= a1_ff;
         p2_ff    <= p2_in;
         sg2_ff   <= ops;
      end
      if (en3) begin
         func3_ff <= func2_ff;
         a3_ff    <= a2_ff;
         c3_ff    <= c3_in;
         sat3_ff  <= clip3[0] || clip3[1] || clip3[2] || clip3[3];
      end
      if (en4) begin
         func4_ff <= func3_ff;
         c4_ff    <= c3_ff;
         p4_ff    <= p4_in;
         sat4_ff  <= sat3_ff;
      end
      if (en5) begin
         r_ff    <= r_in;
         sat5_ff <= sat5_in;
      end
   end

   assign rsp_valid     = v5_ff;
   assign rsp_r_w       = r_ff[W];
   assign rsp_r_x       = r_ff[X];
   assign rsp_r_y       = r_ff[Y];
   assign rsp_r_z       = r_ff[Z];
   assign rsp_saturated = sat5_ff;

endmodule

@@ rtl/qmr_checker.sv @@
// Port-level checker for quaternion_multiply_rotate, attached with a bind.
// Depends only on the top level's ports; no package items are needed.
module qmr_checker #(
   parameter int COMPONENT_WIDTH = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [COMPONENT_WIDTH-1:0] rsp_r_w,
   input logic signed [COMPONENT_WIDTH-1:0] rsp_r_x,
   input logic signed [COMPONENT_WIDTH-1:0] rsp_r_y,
   input logic signed [COMPONENT_WIDTH-1:0] rsp_r_z,
   input logic                              rsp_saturated
);

   // The pipeline holds at most five words.
   localparam logic [2:0] DEPTH = 3'd5;

   logic       req_take;
   logic       rsp_take;
   logic [2:0] count_ff;
   logic [2:0] count_in;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      if (req_take && !rsp_take) begin
         count_in = count_ff + 3'd1;
      end else if (rsp_take && !req_take) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A response never appears without an accepted request behind it.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != 3'd0)
      else $error("response word without an outstanding request");

   // The block never holds more words than it has stages.
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH)
      else $error("more words in flight than pipeline stages");

   // An empty block never pushes back on its requester.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      count_ff == 3'd0 |-> !req_stall)
      else $error("request stalled while the pipeline is empty");

   // A stalled response word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_r_w) && $stable(rsp_r_x)
         && $stable(rsp_r_y) && $stable(rsp_r_z) && $stable(rsp_saturated))
      else $error("stalled response word changed");

endmodule

bind quaternion_multiply_rotate qmr_checker #(
   .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_qmr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_r_w       (rsp_r_w),
   .rsp_r_x       (rsp_r_x),
   .rsp_r_y       (rsp_r_y),
   .rsp_r_z       (rsp_r_z),
   .rsp_saturated (rsp_saturated)
);
